// ----- design/hmfe_pkg.sv -----
// shared types, byte codes and step indexes for the host-mode frame encoder
package hmfe_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  // link framing bytes
  localparam logic [7:0] SOH_BYTE    = 8'h01;
  localparam logic [7:0] ESC_BYTE    = 8'h10;
  localparam logic [7:0] ETB_BYTE    = 8'h17;
  localparam logic [7:0] HDR_UNPROTO = 8'h29;
  localparam logic [7:0] HDR_COMMAND = 8'h40;
  localparam logic [7:0] HDR_DATA    = 8'h20;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_O      = 8'h4F;
  localparam logic [3:0] CTRL_CHANNEL = 4'hF;

  typedef enum logic [1:0] {
    MT_UNPROTO = 2'd0,
    MT_COMMAND = 2'd1,
    MT_DATA    = 2'd2,
    MT_INVALID = 2'd3
  } hmfe_mtype_t;

  // output steps of one job, emitted from lowest index up
  localparam int STEP_REJ  = 0;
  localparam int STEP_SOH  = 1;
  localparam int STEP_HDR  = 2;
  localparam int STEP_ESC  = 3;
  localparam int STEP_BYTE = 4;
  localparam int STEP_ETB  = 5;
  localparam int STEP_SOH2 = 6;
  localparam int STEP_HDR2 = 7;
  localparam int STEP_C    = 8;
  localparam int STEP_O    = 9;
  localparam int STEP_ETB2 = 10;
  localparam int NUM_STEPS = 11;
  localparam int STEP_IDX_W = $clog2(NUM_STEPS);

  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;
    logic [7:0]           data;
    logic [7:0]           hdr;
    logic [7:0]           stat_hdr;
  } hmfe_job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } hmfe_qstat_t;

endpackage

// ----- design/hmfe_if.sv -----
// valid/ready channel interfaces for message items and link bytes
interface hmfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_type;
  logic [3:0] channel;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       no_payload;

  modport source (output valid, msg_type, channel, data_byte, first_byte, last_byte,
                  no_payload, input ready);
  modport sink (input valid, msg_type, channel, data_byte, first_byte, last_byte,
                no_payload, output ready);
endinterface

interface hmfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       rejected;
  logic       run_end;

  modport source (output valid, wire_byte, rejected, run_end, input ready);
  modport sink (input valid, wire_byte, rejected, run_end, output ready);
endinterface

// ----- design/host_mode_frame_encoder.sv -----
// host-mode frame encoder: item front end, job queue, byte sequencer
// an accepted item's first link byte passes queue write, sequencer load and output register
// throughput: one item per cycle accepted while the job queue has room; one link byte
//   per cycle out while the sink is ready; an item makes 0 to 10 link bytes
// the next job loads as the previous one's last byte is emitted, or once queued if idle
// reset: synchronous, active low; clears held type/channel, drop flag, queue and output valid
module host_mode_frame_encoder
  import hmfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hmfe_in_if.sink    in_ch,
  hmfe_out_if.source out_ch
);

  logic        push;
  logic        pop;
  hmfe_job_t   push_job;
  hmfe_job_t   head_job;
  hmfe_qstat_t qstat;

  hmfe_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  hmfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  hmfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .qstat    (qstat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // a reject beat stands alone and carries a zero byte
  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rejected |-> out_ch.run_end && out_ch.wire_byte == 8'h00)
    else $error("reject beat not a lone zero byte");

  // jobs only leave a queue that holds one
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.not_empty)
    else $error("pop from empty job queue");

  // a job with no steps never enters the queue, and no job is pushed while it is full
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_job.steps != '0 && !qstat.full)
    else $error("empty job pushed or queue overrun");

  // a full queue holds off the input side for that cycle
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !in_ch.ready)
    else $error("input ready while job queue full");

endmodule

// ----- design/hmfe_front.sv -----
// front end: accepts message items, tracks type/channel, builds output jobs
module hmfe_front
  import hmfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hmfe_in_if.sink     in_ch,
  input  hmfe_qstat_t qstat,
  output logic        push,
  output hmfe_job_t   job
);

  logic [1:0] held_type_r, held_type_nxt;
  logic [3:0] held_channel_r, held_channel_nxt;
  logic       dropping_r, dropping_nxt;

  logic       accept;
  logic       first;
  logic       last;
  logic       empty;
  logic [1:0] cur_type;
  logic [3:0] cur_chan;
  logic [7:0] ch8;
  logic       needs_esc;
  logic       is_data;

  assign in_ch.ready = !qstat.full;
  assign accept = in_ch.valid && in_ch.ready;
  assign first  = in_ch.first_byte;
  assign last   = in_ch.last_byte;
  assign empty  = in_ch.no_payload;

  always_comb begin
    cur_type = first ? in_ch.msg_type : held_type_r;
    cur_chan = first ? in_ch.channel : held_channel_r;
    // modem channels count from zero, control channel keeps its number
    ch8 = (cur_chan == CTRL_CHANNEL) ? {4'd0, cur_chan} : ({4'd0, cur_chan} - 8'd1);
    needs_esc = in_ch.data_byte inside {ETB_BYTE, ESC_BYTE, SOH_BYTE};
    is_data = (cur_type == MT_DATA);

    job.data     = in_ch.data_byte;
    job.stat_hdr = HDR_COMMAND + ch8;
    case (cur_type)
      MT_UNPROTO: job.hdr = HDR_UNPROTO;
      MT_COMMAND: job.hdr = HDR_COMMAND + ch8;
      default:    job.hdr = HDR_DATA + ch8;
    endcase

    job.steps = '0;
    if (first && in_ch.msg_type == MT_INVALID) begin
      job.steps[STEP_REJ] = 1'b1;
    end else if (first || !dropping_r) begin
      job.steps[STEP_SOH]  = first;
      job.steps[STEP_HDR]  = first;
      job.steps[STEP_ESC]  = !empty && needs_esc;
      job.steps[STEP_BYTE] = !empty;
      job.steps[STEP_ETB]  = last;
      job.steps[STEP_SOH2] = last && is_data;
      job.steps[STEP_HDR2] = last && is_data;
      job.steps[STEP_C]    = last && is_data;
      job.steps[STEP_O]    = last && is_data;
      job.steps[STEP_ETB2] = last && is_data;
    end

    push = accept && (job.steps != '0);

    held_type_nxt    = held_type_r;
    held_channel_nxt = held_channel_r;
    dropping_nxt     = dropping_r;
    if (accept) begin
      if (first) begin
        held_type_nxt    = in_ch.msg_type;
        held_channel_nxt = in_ch.channel;
        dropping_nxt     = (in_ch.msg_type == MT_INVALID) && !last;
      end else if (dropping_r && last) begin
        dropping_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_type_r    <= '0;
      held_channel_r <= '0;
      dropping_r     <= 1'b0;
    end else begin
      held_type_r    <= held_type_nxt;
      held_channel_r <= held_channel_nxt;
      dropping_r     <= dropping_nxt;
    end
  end

endmodule

// ----- design/hmfe_queue.sv -----
// short job queue between front end and byte sequencer
module hmfe_queue
  import hmfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hmfe_job_t   push_job,
  input  logic        pop,
  output hmfe_job_t   head_job,
  output hmfe_qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hmfe_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign qstat.not_empty = (count_r != '0);
  assign qstat.full      = (count_r == CW'(DEPTH));
  assign do_push  = push && !qstat.full;
  assign do_pop   = pop && qstat.not_empty;
  assign head_job = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/hmfe_back.sv -----
// back end: walks the steps of each job and drives one link byte per beat
module hmfe_back
  import hmfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  hmfe_job_t   head_job,
  input  hmfe_qstat_t qstat,
  output logic        pop,
  hmfe_out_if.source  out_ch
);

  logic [NUM_STEPS-1:0]  steps_r, steps_nxt;
  hmfe_job_t             job_r;
  logic                  out_valid_r;
  logic [7:0]            wire_byte_r;
  logic                  rejected_r;
  logic                  run_end_r;

  logic                  advance;
  logic                  emit;
  logic [NUM_STEPS-1:0]  sel;
  logic [NUM_STEPS-1:0]  rest;
  logic [STEP_IDX_W-1:0] idx;
  logic [7:0]            step_byte;
  logic                  load;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.wire_byte = wire_byte_r;
  assign out_ch.rejected  = rejected_r;
  assign out_ch.run_end   = run_end_r;

  always_comb begin
    advance = !out_valid_r || out_ch.ready;
    emit    = advance && (steps_r != '0);
    // lowest pending step
    sel  = steps_r & (~steps_r + NUM_STEPS'(1));
    rest = steps_r & ~sel;
    idx  = '0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (sel[i]) begin
        idx = STEP_IDX_W'(i);
      end
    end
    case (idx)
      STEP_IDX_W'(STEP_REJ):  step_byte = 8'h00;
      STEP_IDX_W'(STEP_SOH):  step_byte = SOH_BYTE;
      STEP_IDX_W'(STEP_HDR):  step_byte = job_r.hdr;
      STEP_IDX_W'(STEP_ESC):  step_byte = ESC_BYTE;
      STEP_IDX_W'(STEP_BYTE): step_byte = job_r.data;
      STEP_IDX_W'(STEP_ETB):  step_byte = ETB_BYTE;
      STEP_IDX_W'(STEP_SOH2): step_byte = SOH_BYTE;
      STEP_IDX_W'(STEP_HDR2): step_byte = job_r.stat_hdr;
      STEP_IDX_W'(STEP_C):    step_byte = CHAR_C;
      STEP_IDX_W'(STEP_O):    step_byte = CHAR_O;
      STEP_IDX_W'(STEP_ETB2): step_byte = ETB_BYTE;
      default:                step_byte = 8'h00;
    endcase

    // take the next job when idle or as the current one finishes
    load = qstat.not_empty && ((steps_r == '0) || (emit && rest == '0));
    pop  = load;

    steps_nxt = steps_r;
    if (load) begin
      steps_nxt = head_job.steps;
    end else if (emit) begin
      steps_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= head_job;
    end
    if (emit) begin
      wire_byte_r <= step_byte;
      rejected_r  <= sel[STEP_REJ];
      run_end_r   <= (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      steps_r <= steps_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (advance) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
